@@ design/mbarc_pkg.sv @@
// shared types, constants and the crc step for the modbus angle response checker
// no dependencies
package mbarc_pkg;

  localparam logic [7:0]  DEV_ADDR_RESET    = 8'd127;
  localparam logic [7:0]  FUNC_READ_HOLD    = 8'h03;
  localparam logic [7:0]  FUNC_READ_HOLD_EX = 8'h83;
  localparam logic [7:0]  ANGLE_BYTE_COUNT  = 8'd4;
  localparam logic [7:0]  EXC_ILL_FUNC      = 8'd1;
  localparam logic [7:0]  EXC_ILL_ADDR      = 8'd2;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [3:0]  POS_MAX           = 4'd15;
  localparam logic [3:0]  POS_LAST_HDR      = 4'd2;
  localparam logic [3:0]  POS_FIRST_DATA    = 4'd3;
  localparam logic [3:0]  POS_LAST_DATA     = 4'd6;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CRC      = 3'd1,
    ST_ADDR     = 3'd2,
    ST_FUNC     = 3'd3,
    ST_COUNT    = 3'd4,
    ST_ILL_FUNC = 3'd5,
    ST_ILL_REG  = 3'd6,
    ST_OTHER    = 3'd7
  } status_t;

  // input stage contents
  typedef struct packed {
    logic       vld;
    logic       last;
    logic [7:0] data;
  } mbarc_item_t;

  // one finished result
  typedef struct packed {
    status_t     status;
    logic [31:0] angle;
    logic        cleared;
  } mbarc_result_t;

  // modbus crc-16 over one byte, reflected
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/mbarc_in_reg.sv @@
// input register stage of the modbus angle response checker
// depends on mbarc_pkg
module mbarc_in_reg import mbarc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  input  logic        out_full,
  output mbarc_item_t item,
  output logic        fire
);

  logic       vld_r, vld_nxt;
  logic       last_r;
  logic [7:0] data_r;
  logic       go;

  // a last byte needs a result slot that is free or draining, other bytes always move
  assign go       = !vld_r || !last_r || !out_full;
  assign in_stall = vld_r && !go;
  assign fire     = vld_r && go;
  assign vld_nxt  = go ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_frame_byte;
      last_r <= in_last_byte;
    end
  end

  assign item = '{vld: vld_r, last: last_r, data: data_r};

endmodule

@@ design/mbarc_frame.sv @@
// frame state, crc and status check of the modbus angle response checker
// depends on mbarc_pkg
module mbarc_frame import mbarc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  mbarc_item_t   item,
  input  logic          fire,
  input  logic [7:0]    dev_addr,
  output mbarc_result_t result
);

  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [23:0] hdr_r, hdr_nxt;
  logic [31:0] data_r, data_nxt;
  logic [15:0] trail_r, trail_nxt;
  logic        warn_r, warn_nxt;

  logic [15:0] crc_upd;
  logic [23:0] hdr_upd;
  logic [31:0] data_upd;
  logic [15:0] rx_crc;
  logic [3:0]  data_pos;
  status_t     status;

  assign data_pos = pos_r - POS_FIRST_DATA;

  always_comb begin
    crc_upd  = (pos_r >= POS_LAST_HDR) ? crc_step(crc_r, trail_r[15:8]) : crc_r;
    hdr_upd  = hdr_r;
    data_upd = data_r;
    if (pos_r <= POS_LAST_HDR) begin
      hdr_upd[{pos_r[1:0], 3'b000} +: 8] = hdr_r[{pos_r[1:0], 3'b000} +: 8] | item.data;
    end else if (pos_r <= POS_LAST_DATA) begin
      data_upd[{data_pos[1:0], 3'b000} +: 8] =
        data_r[{data_pos[1:0], 3'b000} +: 8] | item.data;
    end
    rx_crc = {item.data, trail_r[7:0]};
  end

  // first failing check wins
  always_comb begin
    priority if (pos_r < POS_FIRST_DATA || rx_crc != crc_upd) begin
      status = ST_CRC;
    end else if (hdr_upd[7:0] != dev_addr) begin
      status = ST_ADDR;
    end else if (hdr_upd[15:8] == FUNC_READ_HOLD) begin
      status = (hdr_upd[23:16] == ANGLE_BYTE_COUNT) ? ST_OK : ST_COUNT;
    end else if (hdr_upd[15:8] == FUNC_READ_HOLD_EX) begin
      priority if (hdr_upd[23:16] == EXC_ILL_FUNC) begin
        status = ST_ILL_FUNC;
      end else if (hdr_upd[23:16] == EXC_ILL_ADDR) begin
        status = ST_ILL_REG;
      end else begin
        status = ST_OTHER;
      end
    end else begin
      status = ST_FUNC;
    end
  end

  always_comb begin
    result.status  = status;
    result.angle   = '0;
    result.cleared = 1'b0;
    if (status == ST_OK) begin
      result.angle   = {data_upd[23:16], data_upd[31:24], data_upd[7:0], data_upd[15:8]};
      result.cleared = warn_r;
    end
  end

  always_comb begin
    crc_nxt   = crc_r;
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    data_nxt  = data_r;
    trail_nxt = trail_r;
    warn_nxt  = warn_r;
    if (fire) begin
      if (item.last) begin
        crc_nxt   = CRC_INIT;
        pos_nxt   = '0;
        hdr_nxt   = '0;
        data_nxt  = '0;
        trail_nxt = '0;
        warn_nxt  = (status != ST_OK);
      end else begin
        crc_nxt   = crc_upd;
        pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 4'd1;
        hdr_nxt   = hdr_upd;
        data_nxt  = data_upd;
        trail_nxt = {trail_r[7:0], item.data};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      pos_r   <= '0;
      hdr_r   <= '0;
      data_r  <= '0;
      trail_r <= '0;
      warn_r  <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      data_r  <= data_nxt;
      trail_r <= trail_nxt;
      warn_r  <= warn_nxt;
    end
  end

endmodule

@@ design/mbarc_out_reg.sv @@
// result register of the modbus angle response checker
// depends on mbarc_pkg
module mbarc_out_reg import mbarc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_load,
  input  mbarc_result_t result,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_status,
  output logic [31:0]   out_angle_raw,
  output logic          out_warning_cleared,
  output logic          out_full
);

  logic          vld_r, vld_nxt;
  mbarc_result_t res_r;

  // loads only when the slot is free or draining
  always_comb begin
    vld_nxt = vld_r;
    if (res_load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= result;
    end
  end

  assign out_full            = vld_r && out_stall;
  assign out_valid           = vld_r;
  assign out_status          = res_r.status;
  assign out_angle_raw       = res_r.angle;
  assign out_warning_cleared = res_r.cleared;

endmodule

@@ design/modbus_angle_response_checker.sv @@
// top level of the modbus angle response checker
// depends on mbarc_pkg, mbarc_in_reg, mbarc_frame, mbarc_out_reg
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in_     | input     | in_valid / in_stall | in_frame_byte, in_last_byte
//  out_    | output    | out_valid/out_stall | out_status, out_angle_raw,
//          |           |                     | out_warning_cleared
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_device_address
//
// one byte per clock sustained while in_stall is low; a byte is held in the input register and
// its result, for a last byte only, is loaded into the result register when the byte leaves it
// the bytewise crc and status check sit between the input and result registers
// reset (rst_n low, synchronous) empties both registers, reloads the frame state and
// sets the device address to 127
// in_stall rises only while a last byte waits for an occupied, stalled result register
module modbus_angle_response_checker import mbarc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_angle_raw,
  output logic        out_warning_cleared,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_device_address
);

  mbarc_item_t   item;
  mbarc_result_t result;
  logic          fire;
  logic          out_full;
  logic [7:0]    dev_addr_r;

  // config writes are always taken; write only while idle, the block itself does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_device_address;
    end
  end

  // input register, holds one byte
  mbarc_in_reg u_in_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_byte (in_frame_byte),
    .in_last_byte  (in_last_byte),
    .out_full      (out_full),
    .item          (item),
    .fire          (fire)
  );

  // running crc, captures and the status decision
  mbarc_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .fire     (fire),
    .dev_addr (dev_addr_r),
    .result   (result)
  );

  // result register, one transaction per frame
  mbarc_out_reg u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res_load            (fire && item.last),
    .result              (result),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_angle_raw       (out_angle_raw),
    .out_warning_cleared (out_warning_cleared),
    .out_full            (out_full)
  );

  // angle and cleared flag only ride on an ok status
  a_clean_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_angle_raw == 32'd0 && !out_warning_cleared)
    else $error("non-ok result carries angle or cleared flag");

  // backpressure only comes from a full result register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && item.vld && item.last)
    else $error("input stalled without a blocked result");

  // an accepted byte lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> item.vld)
    else $error("accepted byte lost");

endmodule
